[hw/rtl/pidaw_pkg.sv]
// ----------------------------------------------------------------------------
// PID anti-windup package
// Shared types, opcodes and register indexes for the PID step block.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 48;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_DERIVED = 2'd0,
    OP_GIVEN   = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_TARGET   = 3'd3,
    REG_OUT_LIM  = 3'd4,
    REG_INT_LIM  = 3'd5
  } reg_idx_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,      // capture item, form error and difference
    CMD_CLEAR,     // clear state on the clear opcode, else repeat the last response
    CMD_DIV_INIT,  // start rate division
    CMD_DIV_STEP,  // one quotient bit
    CMD_DIV_DONE,  // finish rate
    CMD_MUL_TI_LO, // low half of integral * gain_i
    CMD_MUL_TI,    // integral * gain_i
    CMD_MUL_TD,    // rate * gain_d
    CMD_SUM,       // error + terms
    CMD_MUL_P,     // sum * gain_p
    CMD_INTEG,     // conditional integration, product
    CMD_INTEG_ADD, // add to integral
    CMD_BND_INIT,  // start bound division
    CMD_BND_DONE,  // apply integral clamp
    CMD_OUT        // clamp output, store result
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_DIV_INIT, ST_DIV, ST_DIV_DONE,
    ST_TI_LO, ST_TI, ST_TD, ST_SUM, ST_P, ST_INTEG, ST_INTEG_ADD,
    ST_BND_INIT, ST_BND, ST_BND_DONE, ST_OUT, ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e cmd;
    logic pass2; // second drive evaluation
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;   // clear, unused opcode or zero elapsed time
    logic derived;  // rate must be divided out
    logic bnd_en;   // integral clamp applies
  } dp_stat_t;

endpackage

[hw/rtl/pidaw_if.sv]
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface pidaw_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/pidaw_ctrl.sv]
// ----------------------------------------------------------------------------
// PID controller sequencer
// State machine that walks the datapath through one step.
// ----------------------------------------------------------------------------
module pidaw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pidaw_pkg::dp_stat_t stat_i,
  output pidaw_pkg::dp_cmd_t  cmd_o
);
  import pidaw_pkg::*;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o.cmd   = CMD_NOP;
    cmd_o.pass2 = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        pass_d = 1'b0;
        if (stat_i.bypass) begin
          cmd_o.cmd = CMD_CLEAR;
          state_d   = ST_DONE;
        end else if (stat_i.derived) begin
          state_d = ST_DIV_INIT;
        end else begin
          state_d = ST_TI_LO;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.cmd = CMD_DIV_INIT;
        cnt_d     = 6'd0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.cmd = CMD_DIV_STEP;
        cnt_d     = cnt_q + 6'd1;
        if (cnt_q == 6'd48) state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        cmd_o.cmd = CMD_DIV_DONE;
        state_d   = ST_TI_LO;
      end
      ST_TI_LO: begin
        cmd_o.cmd = CMD_MUL_TI_LO;
        state_d   = ST_TI;
      end
      ST_TI: begin
        cmd_o.cmd = CMD_MUL_TI;
        state_d   = ST_TD;
      end
      ST_TD: begin
        cmd_o.cmd = CMD_MUL_TD;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.cmd = CMD_SUM;
        state_d   = ST_P;
      end
      ST_P: begin
        cmd_o.cmd = CMD_MUL_P;
        state_d   = pass_q ? ST_OUT : ST_INTEG;
      end
      ST_INTEG: begin
        cmd_o.cmd = CMD_INTEG;
        state_d   = ST_INTEG_ADD;
      end
      ST_INTEG_ADD: begin
        cmd_o.cmd = CMD_INTEG_ADD;
        state_d   = stat_i.bnd_en ? ST_BND_INIT : ST_TI_LO;
        pass_d    = ~stat_i.bnd_en;
      end
      ST_BND_INIT: begin
        cmd_o.cmd = CMD_BND_INIT;
        cnt_d     = 6'd0;
        state_d   = ST_BND;
      end
      ST_BND: begin
        cmd_o.cmd = CMD_DIV_STEP;
        cnt_d     = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = ST_BND_DONE;
      end
      ST_BND_DONE: begin
        cmd_o.cmd = CMD_BND_DONE;
        pass_d    = 1'b1;
        state_d   = ST_TI_LO;
      end
      ST_OUT: begin
        cmd_o.cmd = CMD_OUT;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ap_no_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  ap_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  ap_load_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_LOAD) else $error("accept lost");
endmodule

[hw/rtl/pidaw_dp.sv]
// ----------------------------------------------------------------------------
// PID datapath
// Registers, shared multiplier and bit-serial divider for one PID step.
// ----------------------------------------------------------------------------
module pidaw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_idx_i,
  input  logic [31:0]                cfg_data_i,
  input  logic [1:0]                 in_opcode_i,
  input  logic signed [31:0]         in_measured_i,
  input  logic signed [31:0]         in_given_rate_i,
  input  logic [31:0]                in_elapsed_time_i,
  input  pidaw_pkg::dp_cmd_t         cmd_i,
  output pidaw_pkg::dp_stat_t        stat_o,
  output logic signed [31:0]         response_o,
  output logic                       held_o
);
  import pidaw_pkg::*;

  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;
  localparam logic signed [63:0] Max48 = 64'sd140737488355327;
  localparam logic signed [63:0] Min48 = -64'sd140737488355328;

  function automatic logic signed [63:0] sat64(logic signed [63:0] v,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    sat64 = (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Configuration registers.
  logic signed [31:0] gp_q, gi_q, gd_q, tgt_q, olim_q, ilim_q;
  // Persistent state.
  logic signed [47:0] integ_q;
  logic signed [31:0] prev_q, last_q;
  // Per-item working registers.
  logic [1:0]         op_q;
  logic [31:0]        dt_q;
  logic signed [31:0] err_q, rate_q, ti_q, td_q, sum_q, resp_q;
  logic signed [32:0] diff_q;
  logic               bypass_q, held_q;
  // Shared divider: dividend shifts out MSB first.
  logic [63:0]        dvd_q;
  logic [63:0]        rem_q, dvs_q;
  logic [63:0]        quo_q;
  logic signed [63:0] prod_q;
  // Low partial product of the integral term.
  logic [63:0]        plo_q;

  // The measurement held for the prev update.
  logic signed [31:0] meas_q;
  logic signed [31:0] in_meas_hold;

  // Multiplier signals.
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic [63:0]        ma, mb, mr;
  logic [31:0]        mop;
  logic [63:0]        mprod;
  logic [79:0]        full;
  logic signed [63:0] mul_r;

  // Integration decision.
  logic [31:0]        resp_mag;
  logic               integ_go;
  logic signed [63:0] integ_sum;

  // Integral clamp.
  logic signed [63:0] bound;
  logic signed [63:0] integ_clamped;

  // Output clamp.
  logic signed [31:0] resp_final;

  // Divider and bound operands.
  logic [64:0] trial;
  logic [63:0] pabs, gpm, gim;
  logic [32:0] dmag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_q    <= 32'sd65536;
      gi_q    <= '0;
      gd_q    <= '0;
      tgt_q   <= '0;
      olim_q  <= -32'sd65536;
      ilim_q  <= -32'sd65536;
      integ_q <= '0;
      prev_q  <= '0;
      last_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN_P:  gp_q   <= cfg_data_i;
          REG_GAIN_I:  gi_q   <= cfg_data_i;
          REG_GAIN_D:  gd_q   <= cfg_data_i;
          REG_TARGET:  tgt_q  <= cfg_data_i;
          REG_OUT_LIM: olim_q <= cfg_data_i;
          REG_INT_LIM: ilim_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (cmd_i.cmd)
        CMD_CLEAR: begin
          if (op_q == OP_CLEAR) begin
            integ_q <= '0;
            prev_q  <= '0;
            last_q  <= '0;
          end
        end
        CMD_INTEG: prev_q <= in_meas_hold;
        CMD_INTEG_ADD: if (integ_go) integ_q <= integ_sum[47:0];
        CMD_BND_DONE: integ_q <= integ_clamped[47:0];
        CMD_OUT: last_q <= resp_final;
        default: ;
      endcase
    end
  end

  assign in_meas_hold = meas_q;

  // Multiplier (a*b)>>16 truncated toward zero, |a| < 2^48, |b| < 2^32.
  // One 32x32 product per cycle; the 48-bit integral is multiplied piecewise,
  // the low 32 bits of its magnitude first and then the upper 16 bits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.cmd)
      CMD_MUL_TI_LO: begin mul_a = 64'(integ_q); mul_b = 64'(gi_q); end
      CMD_MUL_TI: begin mul_a = 64'(integ_q); mul_b = 64'(gi_q); end
      CMD_MUL_TD: begin mul_a = 64'(rate_q);  mul_b = 64'(gd_q); end
      CMD_MUL_P:  begin mul_a = 64'(sum_q);   mul_b = 64'(gp_q); end
      CMD_INTEG:  begin mul_a = 64'(err_q);   mul_b = $signed({32'd0, dt_q}); end
      default: ;
    endcase
    ma    = mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
    mb    = mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
    mop   = (cmd_i.cmd == CMD_MUL_TI) ? {16'd0, ma[47:32]} : ma[31:0];
    mprod = 64'(mop) * 64'(mb[31:0]);
    if (cmd_i.cmd == CMD_MUL_TI) full = ({16'd0, mprod} << 32) + 80'(plo_q);
    else full = 80'(mprod);
    mr   = full[79:16];
    if (mr > 64'h4000_0000_0000_0000) mr = 64'h4000_0000_0000_0000;
    mul_r = (mul_a[63] != mul_b[63]) ? -$signed(mr) : $signed(mr);
  end

  // Integration decision from the first drive.
  assign resp_mag = resp_q[31] ? 32'(-resp_q) : resp_q;
  assign integ_go = olim_q[31] || (resp_mag < olim_q) ||
                    (integ_q != 0 && (integ_q[47] != err_q[31]));
  assign integ_sum = sat64(64'(integ_q) + prod_q, Min48, Max48);

  // Integral clamp.
  assign bound = (quo_q > 64'(Max48)) ? Max48 : $signed(quo_q);
  assign integ_clamped = sat64(64'(integ_q), -bound, bound);

  // Output clamp.
  always_comb begin
    resp_final = resp_q;
    if (!olim_q[31] && resp_mag >= olim_q) begin
      resp_final = resp_q[31] ? -olim_q : olim_q;
    end
  end

  // Divider step.
  assign trial = {rem_q, dvd_q[63]} - {1'b0, dvs_q};

  assign gpm  = gp_q[31] ? 64'(-64'(gp_q)) : 64'(gp_q);
  assign gim  = 64'(gi_q);
  assign pabs = 64'(gpm[31:0]) * 64'(gim[31:0]);

  assign dmag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.cmd)
      CMD_LOAD: begin
        op_q     <= in_opcode_i;
        meas_q   <= in_measured_i;
        dt_q     <= in_elapsed_time_i;
        err_q    <= 32'(sat64(64'(tgt_q) - 64'(in_measured_i), Min32, Max32));
        diff_q   <= 33'(in_measured_i) - 33'(prev_q);
        bypass_q <= (in_opcode_i == OP_CLEAR) || (in_opcode_i == OP_NONE) ||
                    (in_elapsed_time_i == '0);
        held_q   <= (in_opcode_i != OP_CLEAR) && (in_opcode_i != OP_NONE) &&
                    (in_elapsed_time_i == '0);
        rate_q   <= in_given_rate_i;
      end
      CMD_CLEAR: resp_q <= (op_q == OP_CLEAR) ? '0 : last_q;
      CMD_DIV_INIT: begin
        // The 49-bit dividend sits at the top so that 49 steps consume it.
        dvd_q <= {dmag, 31'd0};
        dvs_q <= 64'(dt_q);
        rem_q <= '0;
        quo_q <= '0;
      end
      CMD_BND_INIT: begin
        dvd_q <= {ilim_q, 32'd0};
        dvs_q <= pabs;
        rem_q <= '0;
        quo_q <= '0;
      end
      CMD_DIV_STEP: begin
        dvd_q <= {dvd_q[62:0], 1'b0};
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= {rem_q[62:0], dvd_q[63]};
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      CMD_DIV_DONE: rate_q <= 32'(sat64(diff_q[32] ? -$signed(quo_q) : $signed(quo_q),
                                        Min32, Max32));
      CMD_MUL_TI_LO: plo_q <= mprod;
      CMD_MUL_TI: ti_q <= 32'(sat64(mul_r, Min32, Max32));
      CMD_MUL_TD: td_q <= 32'(sat64(mul_r, Min32, Max32));
      CMD_SUM: sum_q <= 32'(sat64(64'(err_q) + 64'(ti_q) + 64'(td_q), Min32, Max32));
      CMD_MUL_P: resp_q <= 32'(sat64(mul_r, Min32, Max32));
      CMD_INTEG: prod_q <= mul_r;
      CMD_OUT: resp_q <= resp_final;
      default: ;
    endcase
  end

  assign stat_o.bypass  = bypass_q;
  assign stat_o.derived = (op_q == OP_DERIVED);
  assign stat_o.bnd_en  = !ilim_q[31] && !gi_q[31] && (gi_q != 0) && (gp_q != 0);
  assign response_o     = resp_q;
  assign held_o         = held_q;
endmodule

[hw/rtl/pid_controller_anti_windup_core.sv]
// ----------------------------------------------------------------------------
// PID controller with anti-windup
// Q16.16 PID step with conditional integration, integral clamp and output saturation.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  in_if     sink       opcode, measured, given_rate, elapsed_time
//  out_if    source     response, held
//  cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// A step presents its result after the load, two passes through the drive
// terms (TI_LO, TI, TD, SUM and P), the integration states INTEG and
// INTEG_ADD and the output clamp. The derived opcode adds the rate division
// and the integral clamp adds the bound division, both on the bit-serial
// divider. Held, clear and unused opcodes go from the load state straight
// to the done state. Reset loads the register defaults and clears the state.
// A result waits in its register until taken; the next word can be accepted
// in the cycle after that.
module pid_controller_anti_windup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  opcode_i,
  input  logic signed [31:0] measured_i,
  input  logic signed [31:0] given_rate_i,
  input  logic [31:0] elapsed_time_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic signed [31:0] response_o,
  output logic        held_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);
  import pidaw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pidaw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  pidaw_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_opcode_i(opcode_i), .in_measured_i(measured_i),
    .in_given_rate_i(given_rate_i), .in_elapsed_time_i(elapsed_time_i),
    .cmd_i(cmd), .stat_o(stat), .response_o, .held_o
  );
endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID anti-windup step block testbench
// Drives words through the valid/ready channels with random idling and
// stalls, predicts each response with an independent Q16.16 model of the
// controller, and compares every returned word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pidaw_pkg::*;

  // Payload layouts of the two channels.
  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] measured;
    logic [31:0] given_rate;
    logic [31:0] elapsed_time;
  } step_word_t;

  typedef struct packed {
    logic [31:0] response;
    logic        held;
  } drive_word_t;

  localparam longint MaxQ32 = 64'sd2147483647;
  localparam longint MinQ32 = -64'sd2147483648;
  localparam longint MaxQ48 = 64'sd140737488355327;
  localparam longint MinQ48 = -64'sd140737488355328;
  localparam int     CycleLimit = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  reg_idx_e    cfg_idx = REG_GAIN_P;
  logic [31:0] cfg_data = '0;
  logic        out_ready = 1'b0;

  pidaw_if #(.T(step_word_t))  step_if ();
  pidaw_if #(.T(drive_word_t)) drive_if ();

  // The clock runs at 100 MHz for the whole run.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pid_controller_anti_windup_core u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .opcode_i      (step_if.data.opcode),
    .measured_i    (step_if.data.measured),
    .given_rate_i  (step_if.data.given_rate),
    .elapsed_time_i(step_if.data.elapsed_time),
    .in_valid_i    (step_if.valid),
    .in_ready_o    (step_if.ready),
    .response_o    (drive_if.data.response),
    .held_o        (drive_if.data.held),
    .out_valid_o   (drive_if.valid),
    .out_ready_i   (out_ready)
  );
  assign drive_if.ready = out_ready;

  // --------------------------------------------------------------------------
  // Controller model. It keeps its own copy of the registers and of the
  // integrator state, and is advanced once for every word the block accepts.
  // --------------------------------------------------------------------------
  longint kp, ki, kd, setpoint, out_lim, int_lim;
  longint integ_acc, prev_meas, last_drive;

  drive_word_t pending_drives[$];
  int          fail_count = 0;
  bit          idle_en = 1'b0;
  bit          stall_en = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic bit [63:0] magnitude(longint v);
    return (v < 0) ? (64'd0 - 64'(v)) : 64'(v);
  endfunction

  // Fixed-point product, truncated toward zero to 16 fraction bits.
  function automatic longint qmul(longint a, longint b);
    bit [63:0] ma, mb, r;
    ma = magnitude(a);
    mb = magnitude(b);
    r = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
    if (r > (64'd1 << 62)) r = 64'd1 << 62;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // Drive from the error, the current integrator and the rate.
  function automatic longint pid_sum(longint err, longint rate);
    longint ti, td, s;
    ti = clip(qmul(integ_acc, ki), MinQ32, MaxQ32);
    td = clip(qmul(rate, kd), MinQ32, MaxQ32);
    s = clip(err + ti + td, MinQ32, MaxQ32);
    return clip(qmul(s, kp), MinQ32, MaxQ32);
  endfunction

  function automatic drive_word_t pid_step(step_word_t w);
    drive_word_t r;
    longint meas, dt, diff, rate, err, resp, bound;
    bit [63:0] q, p, b;
    meas = longint'($signed(w.measured));
    dt = longint'(w.elapsed_time);
    r = '0;
    if (w.opcode == OP_CLEAR) begin
      integ_acc = 0;
      prev_meas = 0;
      last_drive = 0;
      return r;
    end
    if (w.opcode == OP_NONE || dt == 0) begin
      r.response = last_drive[31:0];
      r.held = (w.opcode != OP_NONE);
      return r;
    end
    if (w.opcode == OP_DERIVED) begin
      diff = meas - prev_meas;
      q = (magnitude(diff) << 16) / 64'(dt);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      rate = clip((diff < 0) ? -longint'(q) : longint'(q), MinQ32, MaxQ32);
    end else begin
      rate = longint'($signed(w.given_rate));
    end
    err = clip(setpoint - meas, MinQ32, MaxQ32);
    prev_meas = meas;

    // Conditional integration: only while unsaturated, or when the error
    // pulls the integrator back toward zero.
    resp = pid_sum(err, rate);
    if (out_lim < 0 || magnitude(resp) < 64'(out_lim) ||
        (integ_acc != 0 && ((integ_acc < 0) != (err < 0))))
      integ_acc = clip(integ_acc + qmul(err, dt), MinQ48, MaxQ48);

    if (int_lim >= 0 && ki > 0 && kp != 0) begin
      p = magnitude(kp) * magnitude(ki);
      b = (64'(int_lim) << 32) / p;
      bound = (b > 64'(MaxQ48)) ? MaxQ48 : longint'(b);
      integ_acc = clip(integ_acc, -bound, bound);
    end

    resp = pid_sum(err, rate);
    if (out_lim >= 0 && magnitude(resp) >= 64'(out_lim))
      resp = clip(resp, -out_lim, out_lim);
    last_drive = resp;
    r.response = resp[31:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving tasks.
  // --------------------------------------------------------------------------

  // Sends one word and records its predicted response once it is accepted.
  // The valid line is left high so that back-to-back words need no gap.
  task automatic send_step(opcode_e op, logic [31:0] meas, logic [31:0] rate,
                           logic [31:0] dt);
    step_word_t w;
    int gap;
    w.opcode = op;
    w.measured = meas;
    w.given_rate = rate;
    w.elapsed_time = dt;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      step_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    step_if.valid <= 1'b1;
    step_if.data <= w;
    // The ready line is read before this edge's updates land, which gives
    // the value the block presented at the edge.
    do @(posedge clk); while (!step_if.ready);
    pending_drives.push_back(pid_step(w));
  endtask

  // Waits until every predicted word has come back and the block is idle.
  task automatic drain();
    step_if.valid <= 1'b0;
    do @(posedge clk); while (pending_drives.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(reg_idx_e idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GAIN_P:  kp = longint'($signed(v));
      REG_GAIN_I:  ki = longint'($signed(v));
      REG_GAIN_D:  kd = longint'($signed(v));
      REG_TARGET:  setpoint = longint'($signed(v));
      REG_OUT_LIM: out_lim = longint'($signed(v));
      REG_INT_LIM: int_lim = longint'($signed(v));
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                           logic [31:0] t, logic [31:0] ol, logic [31:0] il);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_TARGET, t);
    write_reg(REG_OUT_LIM, ol);
    write_reg(REG_INT_LIM, il);
  endtask

  // Random Q16.16 value: mostly moderate magnitudes, sometimes any pattern
  // at all, sometimes one of the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(0, 11))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // Default registers: plain proportional path with no limits.
  task automatic test_reset_defaults();
    send_step(OP_DERIVED, 32'h0001_0000, 32'h0, 32'h0001_0000);
    send_step(OP_GIVEN, 32'hFFFF_0000, 32'h0003_0000, 32'h0000_8000);
    send_step(OP_DERIVED, 32'h1234_5678, 32'h0, 32'h0);
    drain();
  endtask

  // Field extremes and every opcode, including the held and unused cases.
  task automatic test_field_extremes();
    send_step(OP_DERIVED, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001);
    send_step(OP_DERIVED, 32'h8000_0000, 32'h0, 32'h0000_0001);
    send_step(OP_DERIVED, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_step(OP_GIVEN, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000);
    send_step(OP_GIVEN, 32'h0, 32'h8000_0000, 32'h0001_0000);
    send_step(OP_GIVEN, 32'h0001_0000, 32'h0, 32'h0);
    send_step(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_step(OP_CLEAR, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
    send_step(OP_NONE, 32'h0, 32'h0, 32'h0);
    drain();
  endtask

  // Saturation, conditional integration and the integral clamp, including a
  // zero integral limit and the case where the proportional gain is zero so
  // the clamp is skipped.
  task automatic test_anti_windup();
    write_all(32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 32'h0010_0000,
              32'h0004_0000, 32'h0008_0000);
    repeat (4) send_step(OP_DERIVED, 32'h0, 32'h0, 32'h0001_0000);
    send_step(OP_DERIVED, 32'h0020_0000, 32'h0, 32'h0001_0000);
    send_step(OP_GIVEN, 32'h0030_0000, 32'hFFF0_0000, 32'h0002_0000);
    drain();
    write_reg(REG_INT_LIM, 32'h0);
    send_step(OP_DERIVED, 32'h0, 32'h0, 32'h0001_0000);
    send_step(OP_DERIVED, 32'hFFF0_0000, 32'h0, 32'h0001_0000);
    drain();
    write_reg(REG_GAIN_P, 32'h0);
    send_step(OP_GIVEN, 32'h0, 32'h1, 32'hFFFF_FFFF);
    send_step(OP_DERIVED, 32'h8000_0000, 32'h0, 32'h0001_0000);
    drain();
  endtask

  // Random words over one register setting. Most words are real steps; a
  // few clear the state, do nothing, or hold.
  task automatic run_random(int count);
    int op_roll;
    opcode_e op;
    for (int n = 0; n < count; n++) begin
      op_roll = $urandom_range(0, 19);
      if (op_roll < 10) op = OP_DERIVED;
      else if (op_roll < 18) op = OP_GIVEN;
      else if (op_roll == 18) op = OP_CLEAR;
      else op = OP_NONE;
      send_step(op, pick_value(), pick_value(), pick_elapsed());
    end
  endtask

  task automatic test_random_settings();
    // Modest gains with both limits on.
    write_all(32'h0001_8000, 32'h0000_4000, 32'h0000_1000, pick_value(),
              32'h0100_0000, 32'h0040_0000);
    run_random(300);
    // Hold off entirely until the block has returned every word.
    drain();
    run_random(50);
    drain();
    // Extreme settings: largest proportional and integral gains, most negative derivative gain, limits at the top.
    write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(250);
    drain();
    // Negative proportional and integral gains, largest derivative gain, limits disabled at their most negative value.
    write_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000);
    run_random(250);
    drain();
    // Small proportional and integral gains, a derivative gain of -1.0, and zero limits.
    write_all(32'h0000_0001, 32'h0000_0100, 32'hFFFF_0000, 32'h0,
              32'h0, 32'h0);
    run_random(250);
    drain();
    // Several fully random settings.
    for (int k = 0; k < 3; k++) begin
      write_all(pick_value(), pick_value(), pick_value(), pick_value(),
                pick_value(), pick_value());
      run_random(200);
      drain();
    end
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_full_rate();
    idle_en = 1'b0;
    stall_en = 1'b0;
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_2000, 32'h0008_0000,
              32'h0020_0000, 32'h0010_0000);
    run_random(200);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Response side: random stall bursts and the checker.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    drive_word_t want;
    if (rst_n && drive_if.valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected word: response %h held %b",
               drive_if.data.response, drive_if.data.held);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (drive_if.data.response !== want.response) begin
          $error("response: expected %h, got %h", want.response,
                 drive_if.data.response);
          fail_count++;
        end
        if (drive_if.data.held !== want.held) begin
          $error("held: expected %b, got %b", want.held, drive_if.data.held);
          fail_count++;
        end
      end
    end
  end

  // A stuck handshake ends the run.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pid_controller_anti_windup_core test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence. Reset is applied once; the model starts from the same
  // register defaults as the block.
  // --------------------------------------------------------------------------
  initial begin
    step_if.valid <= 1'b0;
    step_if.data <= '0;
    kp = 65536;
    ki = 0;
    kd = 0;
    setpoint = 0;
    out_lim = -65536;
    int_lim = -65536;
    integ_acc = 0;
    prev_meas = 0;
    last_drive = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    idle_en = 1'b1;
    stall_en = 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_anti_windup();
    test_random_settings();
    test_full_rate();

    // Allow any stray output to surface before judging.
    repeat (150) @(posedge clk);
    if (fail_count == 0 && pending_drives.size() == 0) begin
      $display("pid_controller_anti_windup_core test passed");
    end else begin
      $display("pid_controller_anti_windup_core test failed");
    end
    $finish;
  end

endmodule
